>>> design/image_median_filter_assert.svh
// Assertion macros for the image median filter.
// Used by image_median_filter.sv; needs no other file.
`ifndef IMAGE_MEDIAN_FILTER_ASSERT_SVH
`define IMAGE_MEDIAN_FILTER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define IMF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("image median filter check failed");

// Next-cycle implication, checked outside reset
`define IMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("image median filter check failed");

`endif

>>> design/imf_pkg.sv
// Shared types and constants of the image median filter.
// No dependencies; used by imf_median, image_median_filter and the testbench.
`timescale 1ns / 1ps

package imf_pkg;

    localparam int PIX_W   = 8;
    localparam int COORD_W = 10;
    localparam int CFG_W   = 11;

    // Largest image dimension the counters cover
    localparam logic [CFG_W-1:0] DIM_LIMIT = 11'd1024;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    // Coordinates that travel with each word
    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } t_tag;

endpackage

>>> design/imf_ram.sv
// Generic simple dual-port RAM with registered, enabled read.
// No dependencies.
`timescale 1ns / 1ps

module imf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/imf_median.sv
// Pipelined rank-select median over N pixels: compare, count, select.
// Depends on imf_pkg.
`timescale 1ns / 1ps

module imf_median #(
    parameter int N    = 25,
    parameter int RANK = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [imf_pkg::PIX_W-1:0]  i_vals [N],
    input  imf_pkg::t_tag              i_tag,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [imf_pkg::PIX_W-1:0]  o_median,
    output imf_pkg::t_tag              o_tag
);

    import imf_pkg::*;

    localparam int CW = $clog2(N);
    localparam logic [CW-1:0] RANK_V = CW'(RANK);

    // stage A: pairwise compare matrix
    logic             r_a_valid;
    logic [PIX_W-1:0] r_a_vals [N];
    logic [N-1:0]     r_a_lt [N];
    t_tag             r_a_tag;
    // stage B: rank of each element
    logic             r_b_valid;
    logic [PIX_W-1:0] r_b_vals [N];
    logic [CW-1:0]    r_b_rank [N];
    t_tag             r_b_tag;
    // stage C: output word
    logic             r_c_valid;
    logic [PIX_W-1:0] r_c_median;
    t_tag             r_c_tag;

    logic             c_rdy, b_rdy, a_rdy;
    logic [N-1:0]     n_lt [N];
    logic [PIX_W-1:0] n_median;

    assign c_rdy   = !r_c_valid || i_ready;
    assign b_rdy   = !r_b_valid || c_rdy;
    assign a_rdy   = !r_a_valid || b_rdy;
    assign o_ready = a_rdy;

    // element j counts below i if smaller, or equal and earlier (stable rank)
    always_comb begin
        for (int i = 0; i < N; i++) begin
            for (int j = 0; j < N; j++) begin
                n_lt[i][j] = (j < i) ? (i_vals[j] <= i_vals[i]) : (i_vals[j] < i_vals[i]);
            end
        end
    end

    // exactly one element holds the wanted rank
    always_comb begin
        n_median = '0;
        for (int i = 0; i < N; i++) begin
            if (r_b_rank[i] == RANK_V) begin
                n_median = n_median | r_b_vals[i];
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (a_rdy) begin
                r_a_valid <= i_valid;
            end
            if (b_rdy) begin
                r_b_valid <= r_a_valid;
            end
            if (c_rdy) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (a_rdy) begin
            r_a_vals <= i_vals;
            r_a_lt   <= n_lt;
            r_a_tag  <= i_tag;
        end
        if (b_rdy) begin
            r_b_vals <= r_a_vals;
            r_b_tag  <= r_a_tag;
            for (int i = 0; i < N; i++) begin
                r_b_rank[i] <= CW'($countones(r_a_lt[i]));
            end
        end
        if (c_rdy) begin
            r_c_median <= n_median;
            r_c_tag    <= r_b_tag;
        end
    end

    assign o_valid  = r_c_valid;
    assign o_median = r_c_median;
    assign o_tag    = r_c_tag;

endmodule

>>> design/image_median_filter.sv
// Top level of the streaming 2-D median filter: position counters,
// line buffers, window and median pipeline. Depends on imf_pkg, imf_ram,
// imf_median and image_median_filter_assert.svh.
//
//   channel   | signals                                   | role
//   ----------+-------------------------------------------+-----------------
//   in        | i_in_valid o_in_ready i_pixel i_frame_start | pixel word in
//   out       | o_out_valid i_out_ready o_median            | result word out
//             | o_out_row o_out_col                         |
//   cfg       | i_cfg_we i_cfg_idx i_cfg_data               | register write
//
// One word per clock sustained while the output is not stalled; the five
// register stages are line-buffer read, window shift, compare, rank count
// and select/output reg. Reset clears counters and valid bits and sets the
// image size registers to 752 by 480; buffers stay undefined.
// Every stage moves on its own when the next one is free, so bubbles
// close up and a stall at the output holds all words without loss.
`timescale 1ns / 1ps

module image_median_filter #(
    parameter int MASK_DIM  = 5,
    parameter int MAX_WIDTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [imf_pkg::PIX_W-1:0]   i_pixel,
    input  logic                        i_frame_start,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [imf_pkg::PIX_W-1:0]   o_median,
    output logic [imf_pkg::COORD_W-1:0] o_out_row,
    output logic [imf_pkg::COORD_W-1:0] o_out_col,
    input  logic                        i_cfg_we,
    input  logic [0:0]                  i_cfg_idx,
    input  logic [imf_pkg::CFG_W-1:0]   i_cfg_data
);

    import imf_pkg::*;

    `include "image_median_filter_assert.svh"

    localparam int HALF = (MASK_DIM - 1) / 2;
    localparam int WIN  = 2 * HALF + 1;
    localparam int NL   = WIN - 1;
    localparam int NWIN = WIN * WIN;
    localparam int RANK = HALF * MASK_DIM + HALF;
    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int WCAP = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam logic [CFG_W-1:0]   WCAP_V = CFG_W'(WCAP);
    localparam logic [CFG_W-1:0]   EDGE_V = CFG_W'(WIN - 1);
    localparam logic [COORD_W-1:0] HALF_V = COORD_W'(HALF);

    // configuration and position
    logic [CFG_W-1:0]   r_image_width, r_image_height;
    logic [COORD_W-1:0] r_row_cnt, r_col_cnt;
    logic [CFG_W-1:0]   w_eff, h_eff, c0, r0, c1, r1;
    logic               in_emit;
    logic [11:0]        addr_ext;
    logic [AW-1:0]      rd_addr;

    // stage 1: line-buffer read in flight
    logic               r_s1_valid, r_s1_emit;
    logic [PIX_W-1:0]   r_s1_pix;
    t_tag               r_s1_tag;
    logic [AW-1:0]      r_s1_addr;
    logic               r_fwd_en;
    logic [PIX_W-1:0]   r_fwd_data [NL];
    logic [PIX_W-1:0]   ram_q [NL];
    logic [PIX_W-1:0]   col_eff [NL];
    logic [PIX_W-1:0]   wr_data [NL];
    logic [PIX_W-1:0]   column [WIN];

    // stage 2: window
    logic [PIX_W-1:0]   r_win [WIN][WIN];
    logic [PIX_W-1:0]   win_flat [NWIN];
    logic               r_s2_valid;
    t_tag               r_s2_tag;

    logic               in_acc, s1_adv, med_ready;
    t_tag               med_tag;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= 11'd752;
            r_image_height <= 11'd480;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
            endcase
        end
    end

    // position of the arriving pixel and of the next one
    always_comb begin
        w_eff = (r_image_width > WCAP_V) ? WCAP_V : r_image_width;
        if (w_eff == '0) begin
            w_eff = 11'd1;
        end
        h_eff = (r_image_height > DIM_LIMIT) ? DIM_LIMIT : r_image_height;
        if (h_eff == '0) begin
            h_eff = 11'd1;
        end
        c0 = i_frame_start ? '0 : {1'b0, r_col_cnt};
        r0 = i_frame_start ? '0 : {1'b0, r_row_cnt};
        if (c0 >= w_eff) begin
            c0 = '0;
            r0 = r0 + 11'd1;
        end
        if (r0 >= h_eff) begin
            r0 = '0;
        end
        in_emit = (r0 >= EDGE_V) && (c0 >= EDGE_V);
        c1 = c0 + 11'd1;
        r1 = r0;
        if (c1 >= w_eff) begin
            c1 = '0;
            r1 = r0 + 11'd1;
            if (r1 >= h_eff) begin
                r1 = '0;
            end
        end
    end

    assign addr_ext = 12'(c0);
    assign rd_addr  = addr_ext[AW-1:0];

    // handshake and stage advance
    assign s1_adv     = r_s1_valid && (!r_s2_valid || med_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    // line buffers; a write and a read of the same column in one cycle
    // are bypassed through the forward register
    for (genvar k = 0; k < NL; k++) begin : g_line
        imf_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .i_clk   (i_clk),
            .i_we    (s1_adv),
            .i_waddr (r_s1_addr),
            .i_wdata (wr_data[k]),
            .i_re    (in_acc),
            .i_raddr (rd_addr),
            .o_rdata (ram_q[k])
        );
        assign col_eff[k] = r_fwd_en ? r_fwd_data[k] : ram_q[k];
        assign column[k]  = col_eff[k];
        if (k < NL - 1) begin : g_shift
            assign wr_data[k] = col_eff[k+1];
        end else begin : g_last
            assign wr_data[k] = r_s1_pix;
        end
    end
    assign column[WIN-1] = r_s1_pix;

    // counters and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt  <= '0;
            r_col_cnt  <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_row_cnt <= r1[COORD_W-1:0];
                r_col_cnt <= c1[COORD_W-1:0];
            end
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s1_adv) begin
                r_s2_valid <= r_s1_emit;
            end else if (med_ready) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    // stage 1 payload and bypass
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix     <= i_pixel;
            r_s1_emit    <= in_emit;
            r_s1_addr    <= rd_addr;
            r_s1_tag.row <= r0[COORD_W-1:0] - HALF_V;
            r_s1_tag.col <= c0[COORD_W-1:0] - HALF_V;
            r_fwd_en     <= s1_adv && (r_s1_addr == rd_addr);
            r_fwd_data   <= wr_data;
        end
    end

    // window shift and stage 2 tag
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            for (int r = 0; r < WIN; r++) begin
                for (int cc = 0; cc < WIN - 1; cc++) begin
                    r_win[r][cc] <= r_win[r][cc+1];
                end
                r_win[r][WIN-1] <= column[r];
            end
            r_s2_tag <= r_s1_tag;
        end
    end

    always_comb begin
        for (int r = 0; r < WIN; r++) begin
            for (int cc = 0; cc < WIN; cc++) begin
                win_flat[r*WIN+cc] = r_win[r][cc];
            end
        end
    end

    // median pipeline with output register
    imf_median #(
        .N    (NWIN),
        .RANK (RANK)
    ) u_median (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_s2_valid),
        .o_ready  (med_ready),
        .i_vals   (win_flat),
        .i_tag    (r_s2_tag),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_median (o_median),
        .o_tag    (med_tag)
    );

    assign o_out_row = med_tag.row;
    assign o_out_col = med_tag.col;

    // checks
    `IMF_ASSERT_NEXT(a_frame_start_pos, i_clk, i_rst_n, in_acc && i_frame_start, r_col_cnt <= 10'd1)
    `IMF_ASSERT_NEXT(a_emit_to_window, i_clk, i_rst_n, s1_adv && r_s1_emit, r_s2_valid)
    `IMF_ASSERT_NEXT(a_window_holds, i_clk, i_rst_n, r_s2_valid && !med_ready, r_s2_valid && $stable(r_s2_tag))

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the streaming 5x5 median filter.
// Depends on imf_pkg and image_median_filter; drives pixel frames, predicts results.
`timescale 1ns / 1ps

module testbench;
    import imf_pkg::*;

    localparam int KS    = 5;
    localparam int HALFW = (KS - 1) / 2;
    localparam int WINW  = 2 * HALFW + 1;
    localparam int MEDRK = HALFW * KS + HALFW;
    localparam int MAXW  = 1024;
    localparam int LIMIT = 400000;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             fs;
    } t_pix_word;

    typedef struct {
        logic [PIX_W-1:0]   median;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } t_med_word;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [PIX_W-1:0]    i_pixel = '0;
    logic                i_frame_start = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [PIX_W-1:0]    o_median;
    logic [COORD_W-1:0]  o_out_row;
    logic [COORD_W-1:0]  o_out_col;
    logic                i_cfg_we = 1'b0;
    logic [0:0]          i_cfg_idx = '0;
    logic [CFG_W-1:0]    i_cfg_data = '0;

    image_median_filter dut (.*);

    always #2 i_clk = ~i_clk;

    // Stimulus and expectation stores
    t_pix_word pixel_queue[$];
    t_med_word median_queue[$];
    int  send_idle = 0, recv_idle = 0;
    int  errors = 0, results_seen = 0, pixels_sent = 0, cycles = 0;
    bit  in_taken = 1'b0;

    // Predictor state: shadow registers, line buffers, window, position
    logic [CFG_W-1:0]   sh_width = 11'd752, sh_height = 11'd480;
    logic [PIX_W-1:0]   lbuf [WINW-1][MAXW];
    logic [PIX_W-1:0]   win  [WINW][WINW];
    int unsigned        row_pos = 0, col_pos = 0;

    function automatic logic [PIX_W-1:0] window_median();
        logic [PIX_W-1:0] v [WINW*WINW];
        logic [PIX_W-1:0] t;
        for (int r = 0; r < WINW; r++)
            for (int c = 0; c < WINW; c++) v[r*WINW+c] = win[r][c];
        for (int i = 0; i < WINW*WINW; i++)
            for (int j = 0; j < WINW*WINW-1-i; j++)
                if (v[j] > v[j+1]) begin
                    t = v[j]; v[j] = v[j+1]; v[j+1] = t;
                end
        return (MEDRK < WINW*WINW) ? v[MEDRK] : 8'd255;
    endfunction

    // Advance the predicted filter by one pixel; queue a result if the window is complete
    task automatic predict_pixel(input t_pix_word w);
        int unsigned ew, eh;
        logic [PIX_W-1:0] column [WINW];
        t_med_word m;
        ew = (sh_width > MAXW) ? MAXW : sh_width;
        if (ew == 0) ew = 1;
        eh = (sh_height > 1024) ? 1024 : sh_height;
        if (eh == 0) eh = 1;
        if (w.fs) begin
            row_pos = 0; col_pos = 0;
        end
        if (col_pos >= ew) begin
            col_pos = 0; row_pos++;
        end
        if (row_pos >= eh) row_pos = 0;
        for (int k = 0; k < WINW-1; k++) column[k] = lbuf[k][col_pos];
        column[WINW-1] = w.pixel;
        for (int k = 0; k < WINW-2; k++) lbuf[k][col_pos] = lbuf[k+1][col_pos];
        lbuf[WINW-2][col_pos] = w.pixel;
        for (int r = 0; r < WINW; r++) begin
            for (int c = 0; c < WINW-1; c++) win[r][c] = win[r][c+1];
            win[r][WINW-1] = column[r];
        end
        if (row_pos >= WINW-1 && col_pos >= WINW-1) begin
            m.median = window_median();
            m.row = COORD_W'(row_pos - HALFW);
            m.col = COORD_W'(col_pos - HALFW);
            median_queue.push_back(m);
        end
        col_pos++;
        if (col_pos >= ew) begin
            col_pos = 0; row_pos++;
            if (row_pos >= eh) row_pos = 0;
        end
    endtask

    // Monitor: acceptances, register writes and result checks at the rising edge
    always @(posedge i_clk) begin
        t_med_word e;
        cycles++;
        in_taken = i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_cfg_we) begin
            if (i_cfg_idx == REG_IMAGE_WIDTH) sh_width = i_cfg_data;
            else if (i_cfg_idx == REG_IMAGE_HEIGHT) sh_height = i_cfg_data;
        end
        if (in_taken) begin
            predict_pixel('{pixel: i_pixel, fs: i_frame_start});
            pixels_sent++;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (median_queue.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: median %0d row %0d col %0d",
                             o_median, o_out_row, o_out_col);
            end else begin
                e = median_queue.pop_front();
                if (e.median !== o_median || e.row !== o_out_row || e.col !== o_out_col) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp median %0d row %0d col %0d, got %0d %0d %0d",
                                 e.median, e.row, e.col, o_median, o_out_row, o_out_col);
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Driver: present pending pixels at the falling edge
    always @(negedge i_clk) begin
        t_pix_word w;
        if (i_rst_n) begin
            if (!i_in_valid || in_taken) begin
                if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
                    w = pixel_queue.pop_front();
                    i_in_valid    <= 1'b1;
                    i_pixel       <= w.pixel;
                    i_frame_start <= w.fs;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Checked at the rising edge, where the driver's updates have settled
    task automatic wait_drained();
        while (pixel_queue.size() > 0 || i_in_valid || median_queue.size() > 0)
            @(posedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // One phase: new frame size, then random frames starting at a frame start
    task automatic run_phase(input int w, input int h, input int n, input int si, input int ri);
        t_pix_word p;
        wait_drained();
        write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
        send_idle = si; recv_idle = ri;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(7))
                0: p.pixel = 8'd0;
                1: p.pixel = 8'd255;
                default: p.pixel = PIX_W'($urandom);
            endcase
            p.fs = (i == 0) || ($urandom_range(79) == 0);
            pixel_queue.push_back(p);
        end
    endtask

    initial begin
        t_pix_word p;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: one 5x5 frame of extremes and a ramp, gives a single result
        write_reg(REG_IMAGE_WIDTH, 11'd5);
        write_reg(REG_IMAGE_HEIGHT, 11'd5);
        send_idle = 19; recv_idle = 79;
        for (int i = 0; i < 25; i++) begin
            p.pixel = (i % 3 == 0) ? 8'd255 : (i % 3 == 1) ? 8'd0 : PIX_W'(i * 37);
            p.fs = (i == 0);
            pixel_queue.push_back(p);
        end

        run_phase(8, 7, 100, 19, 79);
        run_phase(2047, 0, 40, 79, 19);    // width clamps to 1024, height to one row
        run_phase(0, 2047, 40, 79, 19);    // single column, tallest frame
        run_phase(6, 9, 100, 79, 19);
        run_phase(12, 6, 80, 0, 0);
        run_phase(3, 3, 30, 0, 0);         // frame smaller than the window

        wait_drained();
        if (median_queue.size() != 0) errors++;
        $display("covered %0d pixels and %0d filtered words over seven frame sizes",
                 pixels_sent, results_seen);
        $display("including clamped register values and a frame smaller than the window");
        if (errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule
